// ===== hdl/gpsr_pkg.sv =====
// Package for the game pad serial responder: codes, reply templates and shared types.
package gpsr_pkg;

   // Function codes carried in the request tuser.
   localparam logic FUNC_START = 1'b0;

   // Command bytes sent by the console as the first byte of an exchange.
   localparam logic [7:0] CMD_INIT_PRESSURE = 8'h40;
   localparam logic [7:0] CMD_QUERY_MASK    = 8'h41;
   localparam logic [7:0] CMD_POLL          = 8'h42;
   localparam logic [7:0] CMD_CONFIG        = 8'h43;
   localparam logic [7:0] CMD_SET_MODE      = 8'h44;
   localparam logic [7:0] CMD_STATUS        = 8'h45;
   localparam logic [7:0] CMD_QUERY_ACT     = 8'h46;
   localparam logic [7:0] CMD_QUERY_COMB    = 8'h47;
   localparam logic [7:0] CMD_QUERY_MODE    = 8'h4C;
   localparam logic [7:0] CMD_VIB_MAP       = 8'h4D;
   localparam logic [7:0] CMD_PRESSURE_EN   = 8'h4F;

   // Fixed reply bytes.
   localparam logic [7:0] REPLY_START   = 8'hFF;
   localparam logic [7:0] REPLY_ACK     = 8'hF3;
   localparam logic [7:0] REPLY_ID_BYTE = 8'h5A;
   localparam logic [7:0] ID_RESET      = 8'h73;
   localparam logic [7:0] ID_PRESSURE   = 8'h79;

   // Bytes of the reply buffer that templates and polls rewrite in one go.
   localparam int HEAD_BYTES = 8;
   // Largest value the byte index and the reply length can reach.
   localparam int INDEX_MAX = 31;

   // Reply bytes one to seven; byte zero is never shifted out.
   typedef logic [7:1][7:0] reply_head_type;

   // Input state captured for one port by a poll.
   typedef struct packed {
      logic [7:0]  left_y;
      logic [7:0]  left_x;
      logic [7:0]  right_y;
      logic [7:0]  right_x;
      logic [15:0] buttons;
   } latch_type;

   localparam latch_type LATCH_RESET = '{
      left_y: 8'h00, left_x: 8'h00, right_y: 8'h00, right_x: 8'h00, buttons: 16'hFFFF
   };

   function automatic logic [7:0] id_lookup(input logic pressure, input logic mode);
      logic [7:0] id;
      unique case ({pressure, mode})
         2'b00:   id = 8'h41;
         2'b01:   id = 8'h73;
         2'b10:   id = 8'h41;
         default: id = 8'h79;
      endcase
      return id;
   endfunction

   function automatic logic [7:0] slot5_lookup(input logic [1:0] sel);
      logic [7:0] val;
      unique case (sel)
         2'd0:    val = 8'h04;
         2'd1:    val = 8'h07;
         2'd2:    val = 8'h02;
         default: val = 8'h05;
      endcase
      return val;
   endfunction

   function automatic reply_head_type pack_head(
      input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3,
      input logic [7:0] b4, input logic [7:0] b5, input logic [7:0] b6,
      input logic [7:0] b7);
      return {b7, b6, b5, b4, b3, b2, b1};
   endfunction

   function automatic reply_head_type template_head(input logic [7:0] cmd);
      reply_head_type t;
      unique case (cmd)
         CMD_INIT_PRESSURE: t = pack_head(8'h5a, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h5a);
         CMD_QUERY_MASK:    t = pack_head(8'h5a, 8'hff, 8'hff, 8'h03, 8'h00, 8'h00, 8'h5a);
         CMD_SET_MODE:      t = pack_head(8'h5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         CMD_STATUS:        t = pack_head(8'h5a, 8'h03, 8'h02, 8'h01, 8'h02, 8'h01, 8'h00);
         CMD_QUERY_ACT:     t = pack_head(8'h5a, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h0a);
         CMD_QUERY_COMB:    t = pack_head(8'h5a, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00);
         CMD_QUERY_MODE:    t = pack_head(8'h5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         CMD_VIB_MAP:       t = pack_head(8'h5a, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
         CMD_PRESSURE_EN:   t = pack_head(8'h5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5a);
         default:           t = '0;
      endcase
      return t;
   endfunction

endpackage

// ===== hdl/game_pad_serial_responder_unit.sv =====
// Top level of the game pad serial responder.
// A reply word passes through the reply stage register and the output queue to rsp.
// Throughput: one request word per cycle while the reply queue has room; the reply tail
// memory and the per-port poll latch memory each take one read and one write per cycle,
// same-entry accesses forwarded. A three-word reply queue lets request words keep flowing
// while replies wait. Reset is synchronous; valid bits make unwritten entries read as
// their reset values, so there is no clearing pass.
module game_pad_serial_responder_unit import gpsr_pkg::*; #(
   parameter int REPLY_BYTES = 20,
   parameter int PORT_COUNT  = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,  // analog_select
   input  logic        req_tvalid,
   output logic        req_tready,
   // port, data_byte, buttons, right_x, right_y, left_x, left_y, zero fill (low bit up)
   input  logic [63:0] req_tdata,
   input  logic        req_tuser,    // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata     // reply_byte
);

   localparam int PORT_AW    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int TAIL_DEPTH = (REPLY_BYTES > HEAD_BYTES) ? REPLY_BYTES - HEAD_BYTES : 1;
   localparam int TAIL_AW    = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
   localparam int LEN_CAP    = (REPLY_BYTES < INDEX_MAX) ? REPLY_BYTES : INDEX_MAX;
   localparam int OUT_DEPTH  = 3;
   localparam int OUT_AW     = $clog2(OUT_DEPTH);

   // Request fields
   logic        req_func;
   logic        req_port;
   logic [7:0]  req_data_byte;
   logic [15:0] req_buttons;
   logic [7:0]  req_right_x;
   logic [7:0]  req_right_y;
   logic [7:0]  req_left_x;
   logic [7:0]  req_left_y;
   logic        req_accept;

   // Control and per-port state
   logic                analog_select_ff;
   logic [PORT_AW-1:0]  active_port_ff, active_port_in;
   logic [4:0]          byte_index_ff, byte_index_in;
   logic [7:0]          command_ff, command_in;
   logic [4:0]          reply_length_ff, reply_length_in;
   reply_head_type      head_ff, head_in;
   logic [7:0]          pad_id_ff [PORT_COUNT];
   logic [7:0]          pad_id_in [PORT_COUNT];
   logic                analog_flag_ff [PORT_COUNT];
   logic                analog_flag_in [PORT_COUNT];
   logic                pressure_flag_ff [PORT_COUNT];
   logic                pressure_flag_in [PORT_COUNT];
   logic                stick_blank_ff [PORT_COUNT];
   logic                stick_blank_in [PORT_COUNT];
   logic [4:0]          slot0_ff [PORT_COUNT];
   logic [4:0]          slot0_in [PORT_COUNT];
   logic [4:0]          slot1_ff [PORT_COUNT];
   logic [4:0]          slot1_in [PORT_COUNT];

   // Poll latch memory, one entry per port
   latch_type           latch_mem [PORT_COUNT];
   logic [PORT_COUNT-1:0] latch_vld_ff;
   latch_type           latch_q_ff;
   latch_type           poll_data;
   logic                latch_we;
   logic [PORT_AW-1:0]  latch_rd_port;

   // Reply buffer tail memory, bytes from HEAD_BYTES upwards
   logic [7:0]            tail_mem [TAIL_DEPTH];
   logic [TAIL_DEPTH-1:0] tail_vld_ff;
   logic [7:0]            tail_q_ff;
   logic [TAIL_AW-1:0]    tail_addr;
   logic                  tail_we;
   logic [7:0]            tail_wdata;

   // Working values of the request stage
   logic [7:0]  ans_byte;
   logic        ans_tail;
   logic        handled;
   logic [4:0]  read_idx;
   logic [3:0]  half;
   logic [5:0]  len_raw;
   logic [7:0]  poll_id;
   logic [7:0]  put_val;

   // Reply stage and output queue
   logic               b_valid_ff;
   logic               b_tail_ff;
   logic [7:0]         b_byte_ff;
   logic [7:0]         b_result;
   logic [7:0]         out_fifo [OUT_DEPTH];
   logic [OUT_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [OUT_AW:0]    count_ff;
   logic               push, pop;

   assign req_func      = req_tuser;
   assign req_port      = req_tdata[0];
   assign req_data_byte = req_tdata[8:1];
   assign req_buttons   = req_tdata[24:9];
   assign req_right_x   = req_tdata[32:25];
   assign req_right_y   = req_tdata[40:33];
   assign req_left_x    = req_tdata[48:41];
   assign req_left_y    = req_tdata[56:49];

   assign req_tready = (count_ff + {{OUT_AW{1'b0}}, b_valid_ff}) < (OUT_AW + 1)'(OUT_DEPTH);
   assign req_accept = req_tvalid && req_tready;

   assign tail_addr = TAIL_AW'(byte_index_ff - 5'(HEAD_BYTES));

   // Request stage: works out the reply word and the next state combinationally.
   always_comb begin
      active_port_in   = active_port_ff;
      byte_index_in    = byte_index_ff;
      command_in       = command_ff;
      reply_length_in  = reply_length_ff;
      head_in          = head_ff;
      pad_id_in        = pad_id_ff;
      analog_flag_in   = analog_flag_ff;
      pressure_flag_in = pressure_flag_ff;
      stick_blank_in   = stick_blank_ff;
      slot0_in         = slot0_ff;
      slot1_in         = slot1_ff;
      latch_we         = 1'b0;
      poll_data        = latch_q_ff;
      tail_we          = 1'b0;
      tail_wdata       = '0;
      ans_byte         = '0;
      ans_tail         = 1'b0;
      handled          = 1'b0;
      read_idx         = byte_index_ff;
      half             = 4'((byte_index_ff - 5'd1) >> 1);
      len_raw          = '0;
      poll_id          = '0;
      put_val          = '0;

      if (req_func == FUNC_START) begin
         active_port_in = (PORT_COUNT > 1) ? PORT_AW'(req_port) : '0;
         byte_index_in  = '0;
         ans_byte       = REPLY_START;
      end else begin
         if (byte_index_ff == '0) begin
            byte_index_in = 5'd1;
            command_in    = req_data_byte;
            read_idx      = 5'd1;
            handled       = 1'b1;
            unique case (req_data_byte)
               CMD_INIT_PRESSURE, CMD_QUERY_MASK, CMD_SET_MODE, CMD_QUERY_ACT,
               CMD_QUERY_COMB, CMD_QUERY_MODE, CMD_VIB_MAP: begin
                  head_in         = template_head(req_data_byte);
                  reply_length_in = 5'(HEAD_BYTES);
                  ans_byte        = REPLY_ACK;
               end
               CMD_STATUS: begin
                  head_in         = template_head(req_data_byte);
                  head_in[4]      = {7'b0, analog_flag_ff[active_port_ff]};
                  reply_length_in = 5'(HEAD_BYTES);
                  ans_byte        = REPLY_ACK;
               end
               CMD_PRESSURE_EN: begin
                  pad_id_in[active_port_ff]        = ID_PRESSURE;
                  pressure_flag_in[active_port_ff] = 1'b1;
                  head_in                          = template_head(req_data_byte);
                  reply_length_in                  = 5'(HEAD_BYTES);
                  ans_byte                         = REPLY_ACK;
               end
               CMD_POLL, CMD_CONFIG: begin
                  if (req_data_byte == CMD_POLL) begin
                     // A poll forces the mode of every port and drops the motor map.
                     for (int q = 0; q < PORT_COUNT; q++) begin
                        analog_flag_in[q] = analog_select_ff;
                        slot0_in[q]       = '0;
                        slot1_in[q]       = '0;
                        pad_id_in[q]      = id_lookup(pressure_flag_ff[q], analog_select_ff);
                     end
                     latch_we          = 1'b1;
                     poll_data.buttons = {req_buttons[7:0], req_buttons[15:8]};
                     poll_data.right_x = req_right_x;
                     poll_data.right_y = req_right_y;
                     poll_data.left_x  = req_left_x;
                     poll_data.left_y  = req_left_y;
                  end
                  poll_id = pad_id_in[active_port_ff];
                  len_raw = 6'd2 + {1'b0, poll_id[3:0], 1'b0};
                  reply_length_in = (len_raw > 6'(LEN_CAP)) ? 5'(LEN_CAP) : len_raw[4:0];
                  head_in[1] = REPLY_ID_BYTE;
                  head_in[2] = poll_data.buttons[15:8];
                  head_in[3] = poll_data.buttons[7:0];
                  if (req_data_byte == CMD_CONFIG && stick_blank_ff[active_port_ff]) begin
                     head_in[4] = '0;
                     head_in[5] = '0;
                     head_in[6] = '0;
                     head_in[7] = '0;
                     ans_byte   = REPLY_ACK;
                  end else begin
                     head_in[4] = poll_data.right_x;
                     head_in[5] = poll_data.right_y;
                     head_in[6] = poll_data.left_x;
                     head_in[7] = poll_data.left_y;
                     ans_byte   = poll_id;
                  end
               end
               default: begin
                  handled = 1'b0;
               end
            endcase
         end

         if (!handled) begin
            if (byte_index_ff != '0) begin
               unique case (command_ff)
                  CMD_CONFIG: begin
                     if (byte_index_ff == 5'd2) begin
                        stick_blank_in[active_port_ff] = (req_data_byte != 8'h00);
                     end
                  end
                  CMD_SET_MODE: begin
                     if (byte_index_ff == 5'd2) begin
                        analog_flag_in[active_port_ff] = req_data_byte[0];
                        slot0_in[active_port_ff]       = '0;
                        slot1_in[active_port_ff]       = '0;
                        pad_id_in[active_port_ff]      =
                           id_lookup(pressure_flag_ff[active_port_ff], req_data_byte[0]);
                     end
                  end
                  CMD_QUERY_ACT: begin
                     if (byte_index_ff == 5'd2) begin
                        if (req_data_byte == 8'h00) begin
                           head_in[5] = 8'h02;
                           head_in[6] = 8'h00;
                           head_in[7] = 8'h0a;
                        end else if (req_data_byte == 8'h01) begin
                           head_in[5] = 8'h01;
                           head_in[6] = 8'h01;
                           head_in[7] = 8'h14;
                        end
                     end
                  end
                  CMD_QUERY_MODE: begin
                     if (byte_index_ff == 5'd2) begin
                        head_in[5] = slot5_lookup(req_data_byte[1:0]);
                     end
                  end
                  CMD_VIB_MAP: begin
                     if (byte_index_ff >= 5'd2) begin
                        // The byte mapped to the second motor wins when both slots match.
                        if (byte_index_ff == slot0_ff[active_port_ff] ||
                            byte_index_ff == slot1_ff[active_port_ff]) begin
                           put_val = (byte_index_ff == slot1_ff[active_port_ff]) ? 8'h01 : 8'h00;
                           if (byte_index_ff < 5'(HEAD_BYTES)) begin
                              head_in[byte_index_ff[2:0]] = put_val;
                           end else if ({1'b0, byte_index_ff} < 6'(REPLY_BYTES)) begin
                              tail_we    = 1'b1;
                              tail_wdata = put_val;
                           end
                        end
                        if (req_data_byte == 8'h00 || req_data_byte == 8'h01) begin
                           if (req_data_byte == 8'h00) begin
                              slot0_in[active_port_ff] = byte_index_ff;
                           end else begin
                              slot1_in[active_port_ff] = byte_index_ff;
                           end
                           if (pad_id_ff[active_port_ff][3:0] < half) begin
                              pad_id_in[active_port_ff] = {pad_id_ff[active_port_ff][7:4], half};
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if (byte_index_ff >= reply_length_ff) begin
               ans_byte = '0;
            end else begin
               if (read_idx < 5'(HEAD_BYTES)) begin
                  ans_byte = head_in[read_idx[2:0]];
               end else if ({1'b0, read_idx} < 6'(REPLY_BYTES)) begin
                  ans_tail = 1'b1;
               end else begin
                  ans_byte = '0;
               end
               if (read_idx < 5'(INDEX_MAX)) begin
                  byte_index_in = read_idx + 5'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         analog_select_ff <= 1'b1;
      end else if (csr_wr_en) begin
         analog_select_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_port_ff   <= '0;
         byte_index_ff    <= '0;
         command_ff       <= '0;
         reply_length_ff  <= '0;
         pad_id_ff        <= '{default: ID_RESET};
         analog_flag_ff   <= '{default: 1'b1};
         pressure_flag_ff <= '{default: 1'b0};
         stick_blank_ff   <= '{default: 1'b0};
         slot0_ff         <= '{default: 5'd0};
         slot1_ff         <= '{default: 5'd0};
      end else if (req_accept) begin
         active_port_ff   <= active_port_in;
         byte_index_ff    <= byte_index_in;
         command_ff       <= command_in;
         reply_length_ff  <= reply_length_in;
         pad_id_ff        <= pad_id_in;
         analog_flag_ff   <= analog_flag_in;
         pressure_flag_ff <= pressure_flag_in;
         stick_blank_ff   <= stick_blank_in;
         slot0_ff         <= slot0_in;
         slot1_ff         <= slot1_in;
      end
   end

   // Head bytes are always fully loaded before the reply length lets them be read.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         head_ff <= head_in;
      end
   end

   // The latch read register always holds the entry of the active port.
   assign latch_rd_port = req_accept ? active_port_in : active_port_ff;

   always_ff @(posedge clock) begin
      if (req_accept && latch_we) begin
         latch_mem[active_port_ff] <= poll_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_vld_ff <= '0;
         latch_q_ff   <= LATCH_RESET;
      end else begin
         if (req_accept && latch_we) begin
            latch_vld_ff[active_port_ff] <= 1'b1;
         end
         if (req_accept && latch_we && latch_rd_port == active_port_ff) begin
            latch_q_ff <= poll_data;
         end else if (latch_vld_ff[latch_rd_port]) begin
            latch_q_ff <= latch_mem[latch_rd_port];
         end else begin
            latch_q_ff <= LATCH_RESET;
         end
      end
   end

   // Tail memory: a byte written by this word is forwarded to its own read.
   always_ff @(posedge clock) begin
      if (req_accept && tail_we) begin
         tail_mem[tail_addr] <= tail_wdata;
      end
      if (req_accept && ans_tail) begin
         if (tail_we) begin
            tail_q_ff <= tail_wdata;
         end else if (tail_vld_ff[tail_addr]) begin
            tail_q_ff <= tail_mem[tail_addr];
         end else begin
            tail_q_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_vld_ff <= '0;
      end else if (req_accept && tail_we) begin
         tail_vld_ff[tail_addr] <= 1'b1;
      end
   end

   // Reply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_byte_ff <= ans_byte;
         b_tail_ff <= ans_tail;
      end
   end

   assign b_result = b_tail_ff ? tail_q_ff : b_byte_ff;

   // Output queue; admission control above guarantees room for every pushed word.
   assign push       = b_valid_ff;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = out_fifo[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         out_fifo[wr_ptr_ff] <= b_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == OUT_AW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == OUT_AW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== hdl/gpsr_checker.sv =====
// Port-level checks for the game pad serial responder, bound to its top level.
module gpsr_checker import gpsr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // With nothing queued on the reply side the block must be able to take a word.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side stalled while the reply queue is empty");

   // A reply only appears after an accepted request word passes the reply stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("reply word appeared without a matching request word");

   // A start word reaching an empty pipeline is answered with the start reply.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == FUNC_START && !rsp_tvalid &&
       !$past(req_tvalid && req_tready))
      |=> ##1 (rsp_tvalid && rsp_tdata == REPLY_START))
      else $error("start word not answered with the start reply");

   // A stalled reply word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled reply word changed or vanished");

endmodule

bind game_pad_serial_responder_unit gpsr_checker u_gpsr_checker (.*);
